// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the telemetry codec RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STFC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("stfc assertion failed");

// next-cycle implication
`define STFC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("stfc assertion failed");

`endif

// ----- rtl/stfc_pkg.sv -----
// ----------------------------------------------------------------------------
// stfc_pkg
// Types and constants shared by the telemetry frame codec modules.
// ----------------------------------------------------------------------------
package stfc_pkg;

    localparam int DATA_BITS_DEF = 12;
    localparam int HDR_BITS      = 3;
    localparam int TX_W          = 16;
    localparam int RX_W          = 16;
    localparam int POS_W         = 24;
    localparam int FLD_W         = 12;
    localparam int TMO_W         = 8;

    // position scaling divider
    localparam int DEN_W     = POS_W + 1;
    localparam int NUM_W     = 34;
    localparam int SCALE_W   = 10;
    localparam int POS_SCALE = 1000;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // stream payloads
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PULL_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COMMAND  = 3'd5;

    localparam logic [POS_W-1:0] PULL_LIMIT_RST    = 24'd0;
    localparam logic [POS_W-1:0] PUSH_LIMIT_RST    = 24'd1000;
    localparam logic [TMO_W-1:0] TIMEOUT_LIMIT_RST = 8'd10;
    localparam logic [FLD_W-1:0] HOLD_RST          = 12'd0;

    // frame rotation
    localparam logic [2:0] FRM_POSITION    = 3'd0;
    localparam logic [2:0] FRM_TEMPERATURE = 3'd1;
    localparam logic [2:0] FRM_RPM         = 3'd2;
    localparam logic [2:0] FRM_STATUS      = 3'd3;
    localparam logic [2:0] FRM_ERROR       = 3'd4;

    // header codes
    localparam logic [HDR_BITS-1:0] TXH_NONE        = 3'd0;
    localparam logic [HDR_BITS-1:0] TXH_POSITION    = 3'd1;
    localparam logic [HDR_BITS-1:0] TXH_TEMPERATURE = 3'd2;
    localparam logic [HDR_BITS-1:0] TXH_RPM         = 3'd3;
    localparam logic [HDR_BITS-1:0] TXH_STATUS      = 3'd4;
    localparam logic [HDR_BITS-1:0] TXH_ERROR       = 3'd5;
    localparam logic [HDR_BITS-1:0] RXH_SPEED       = 3'd1;
    localparam logic [HDR_BITS-1:0] RXH_MODE        = 3'd2;
    localparam logic [HDR_BITS-1:0] RXH_COMMAND     = 3'd3;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic div_step;
        logic finish;
    } stfc_cmd_t;

    typedef struct packed {
        logic pos_frame;
        logic out_free;
    } stfc_status_t;

endpackage

// ----- rtl/spi_telemetry_frame_codec.sv -----
// ----------------------------------------------------------------------------
// spi_telemetry_frame_codec: after the input transfer a position frame runs prep,
// multiply, 17 two-bit divider steps and finish; other frames go straight to finish.
// Finish waits for a free output, and no new input is taken until the item is done.
// Synchronous active-low reset: rotation and counters cleared, settings to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_telemetry_frame_codec #(
    parameter int DATA_BITS = stfc_pkg::DATA_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // rx_word[15:0], position[39:16], temperature_tenths[51:40], rpm[63:52],
    // status[75:64], error_flags[87:76]
    input  logic [stfc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tx_word[15:0], speed_setting[27:16], mode_setting[39:28],
    // command_setting[51:40], timed_out[52], zero[55:53]
    output logic [stfc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import stfc_pkg::*;

    logic [POS_W-1:0] pull_limit_reg, push_limit_reg;
    logic [TMO_W-1:0] timeout_limit_reg;
    logic [FLD_W-1:0] hold_speed_reg, hold_mode_reg, hold_command_reg;

    stfc_cmd_t    ctrl_cmd;
    stfc_status_t dp_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pull_limit_reg    <= PULL_LIMIT_RST;
            push_limit_reg    <= PUSH_LIMIT_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
            hold_speed_reg    <= HOLD_RST;
            hold_mode_reg     <= HOLD_RST;
            hold_command_reg  <= HOLD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PULL_LIMIT:    pull_limit_reg    <= cfg_data[POS_W-1:0];
                CFG_PUSH_LIMIT:    push_limit_reg    <= cfg_data[POS_W-1:0];
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[TMO_W-1:0];
                CFG_HOLD_SPEED:    hold_speed_reg    <= cfg_data[FLD_W-1:0];
                CFG_HOLD_MODE:     hold_mode_reg     <= cfg_data[FLD_W-1:0];
                CFG_HOLD_COMMAND:  hold_command_reg  <= cfg_data[FLD_W-1:0];
                default:           ;
            endcase
        end
    end

    stfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    stfc_dpath #(
        .DATA_BITS (DATA_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (ctrl_cmd),
        .status        (dp_status),
        .s_tdata       (s_tdata),
        .pull_limit    (pull_limit_reg),
        .push_limit    (push_limit_reg),
        .timeout_limit (timeout_limit_reg),
        .hold_speed    (hold_speed_reg),
        .hold_mode     (hold_mode_reg),
        .hold_command  (hold_command_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    `STFC_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `STFC_ASSERT_IMP(a_out_from_finish, aclk, aresetn, $rose(m_tvalid), $past(ctrl_cmd.finish))
    `STFC_ASSERT_IMP(a_div_pos_only, aclk, aresetn, ctrl_cmd.div_step, dp_status.pos_frame)

endmodule

// ----- rtl/stfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// stfc_ctrl
// Sequencer: input capture, position scaling divide, frame completion.
// ----------------------------------------------------------------------------
module stfc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  stfc_pkg::stfc_status_t status,
    output stfc_pkg::stfc_cmd_t    cmd
);
    import stfc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.pos_frame ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/stfc_dpath.sv -----
// ----------------------------------------------------------------------------
// stfc_dpath
// Datapath: operand capture, position scaling divider, frame build,
// received word decode, link timeout and the result register.
// ----------------------------------------------------------------------------
module stfc_dpath #(
    parameter int DATA_BITS = stfc_pkg::DATA_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  stfc_pkg::stfc_cmd_t         cmd,
    output stfc_pkg::stfc_status_t      status,
    input  logic [stfc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [stfc_pkg::POS_W-1:0]  pull_limit,
    input  logic [stfc_pkg::POS_W-1:0]  push_limit,
    input  logic [stfc_pkg::TMO_W-1:0]  timeout_limit,
    input  logic [stfc_pkg::FLD_W-1:0]  hold_speed,
    input  logic [stfc_pkg::FLD_W-1:0]  hold_mode,
    input  logic [stfc_pkg::FLD_W-1:0]  hold_command,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [stfc_pkg::M_TDATA_W-1:0] m_tdata
);
    import stfc_pkg::*;

    // captured item
    logic [RX_W-1:0]  rx_reg;
    logic [POS_W-1:0] pos_reg;
    logic [FLD_W-1:0] temp_reg, rpm_reg, stat_reg, err_reg;

    // divider
    logic [DEN_W-1:0] mag_reg, dvs_reg, rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic             neg_reg, dzero_reg;
    logic [DEN_W-1:0] diff, den;
    logic [DEN_W+SCALE_W-1:0] prod;

    // telemetry state
    logic [2:0]       frame_reg, frame_next;
    logic [TMO_W-1:0] zcnt_reg, zcnt_next;
    logic [FLD_W-1:0] speed_reg, speed_next;
    logic [FLD_W-1:0] mode_reg, mode_next;
    logic [FLD_W-1:0] command_reg, command_next;
    logic             timed;

    logic [DATA_BITS-1:0] pos_data, q_low, frm_data, rx_data;
    logic [HDR_BITS-1:0]  frm_hdr, rx_hdr;
    logic [TX_W-1:0]      tx_word;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign diff = {pos_reg[POS_W-1], pos_reg} - {pull_limit[POS_W-1], pull_limit};
    assign den  = {push_limit[POS_W-1], push_limit} - {pull_limit[POS_W-1], pull_limit};
    assign prod = mag_reg * SCALE_W'(POS_SCALE);

    // two restoring quotient bits per step
    always_comb begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem_mid;
        logic [NUM_W-1:0] quo_mid;
        trial   = {rem_reg, quo_reg[NUM_W-1]};
        quo_mid = {quo_reg[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_mid    = DEN_W'(trial - {1'b0, dvs_reg});
            quo_mid[0] = 1'b1;
        end else begin
            rem_mid = trial[DEN_W-1:0];
        end
        trial    = {rem_mid, quo_mid[NUM_W-1]};
        quo_next = {quo_mid[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next    = DEN_W'(trial - {1'b0, dvs_reg});
            quo_next[0] = 1'b1;
        end else begin
            rem_next = trial[DEN_W-1:0];
        end
    end

    assign q_low    = quo_reg[DATA_BITS-1:0];
    assign pos_data = dzero_reg ? '0 : (neg_reg ? (~q_low + 1'b1) : q_low);

    always_comb begin
        case (frame_reg)
            FRM_POSITION: begin
                frm_hdr  = TXH_POSITION;
                frm_data = pos_data;
            end
            FRM_TEMPERATURE: begin
                frm_hdr  = TXH_TEMPERATURE;
                frm_data = temp_reg[DATA_BITS-1:0];
            end
            FRM_RPM: begin
                frm_hdr  = TXH_RPM;
                frm_data = rpm_reg[DATA_BITS-1:0];
            end
            FRM_STATUS: begin
                frm_hdr  = TXH_STATUS;
                frm_data = stat_reg[DATA_BITS-1:0];
            end
            FRM_ERROR: begin
                frm_hdr  = TXH_ERROR;
                frm_data = err_reg[DATA_BITS-1:0];
            end
            default: begin
                frm_hdr  = TXH_NONE;
                frm_data = '0;
            end
        endcase
    end

    assign tx_word    = TX_W'({~^{frm_hdr, frm_data}, frm_hdr, frm_data});
    assign frame_next = (frame_reg >= FRM_ERROR) ? FRM_POSITION : frame_reg + 1'b1;

    assign rx_hdr  = rx_reg[DATA_BITS+HDR_BITS-1:DATA_BITS];
    assign rx_data = rx_reg[DATA_BITS-1:0];

    always_comb begin
        if (rx_reg == '0) begin
            zcnt_next = (zcnt_reg == '1) ? zcnt_reg : zcnt_reg + 1'b1;
        end else begin
            zcnt_next = '0;
        end
        timed        = zcnt_next > timeout_limit;
        speed_next   = timed ? hold_speed   : speed_reg;
        mode_next    = timed ? hold_mode    : mode_reg;
        command_next = timed ? hold_command : command_reg;
        if (^rx_reg) begin
            case (rx_hdr)
                RXH_SPEED:   speed_next   = FLD_W'(rx_data);
                RXH_MODE:    mode_next    = FLD_W'(rx_data);
                RXH_COMMAND: command_next = FLD_W'(rx_data);
                default:     ;
            endcase
        end
    end

    assign status.pos_frame = (frame_reg == FRM_POSITION);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rx_reg   <= s_tdata[15:0];
            pos_reg  <= s_tdata[39:16];
            temp_reg <= s_tdata[51:40];
            rpm_reg  <= s_tdata[63:52];
            stat_reg <= s_tdata[75:64];
            err_reg  <= s_tdata[87:76];
        end
        if (cmd.prep) begin
            mag_reg   <= diff[DEN_W-1] ? -diff : diff;
            dvs_reg   <= den[DEN_W-1] ? -den : den;
            neg_reg   <= diff[DEN_W-1] ^ den[DEN_W-1];
            dzero_reg <= (den == '0);
        end
        if (cmd.mul) begin
            quo_reg <= prod[NUM_W-1:0];
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.finish) begin
            m_tdata_reg <= M_TDATA_W'({timed, command_next, mode_next, speed_next, tx_word});
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg    <= FRM_POSITION;
            zcnt_reg     <= '0;
            speed_reg    <= '0;
            mode_reg     <= '0;
            command_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                frame_reg    <= frame_next;
                zcnt_reg     <= zcnt_next;
                speed_reg    <= speed_next;
                mode_reg     <= mode_next;
                command_reg  <= command_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/tb_spi_telemetry_frame_codec.sv -----
// ----------------------------------------------------------------------------
// tb_spi_telemetry_frame_codec
// Stream-level check of the telemetry frame codec. A local model of the
// frame rotation, position scaling, parity, link timeout and setting decode
// predicts one result per input transfer; the monitor compares every output
// transfer field by field. Directed cases cover the field extremes, limits
// and timeout corners, then random traffic runs under several settings and
// handshake idle mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_spi_telemetry_frame_codec;
    timeunit 1ns;
    timeprecision 1ps;

    import stfc_pkg::*;

    localparam int SETTLE_CYCLES  = 30;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 40;

    // error_flags, status, rpm, temperature, position, rx_word (lowest)
    typedef struct packed {
        logic [11:0]        error_flags;
        logic [11:0]        status;
        logic [11:0]        rpm;
        logic [11:0]        temperature;
        logic signed [23:0] position;
        logic [15:0]        rx_word;
    } exchange_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic        timed_out;
        logic [11:0] command;
        logic [11:0] mode;
        logic [11:0] speed;
        logic [15:0] tx_word;
    } frame_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    spi_telemetry_frame_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // settings shadow
    logic signed [23:0] pull_lim = 24'sd0;
    logic signed [23:0] push_lim = 24'sd1000;
    logic [7:0]         tmo_lim  = 8'd10;
    logic [11:0]        hold_spd = '0;
    logic [11:0]        hold_md  = '0;
    logic [11:0]        hold_cmd = '0;

    // codec state
    logic [2:0]  tx_slot  = FRM_POSITION;
    logic [7:0]  zero_run = '0;
    logic [11:0] speed_q  = '0;
    logic [11:0] mode_q   = '0;
    logic [11:0] command_q = '0;

    frame_result_t expected_frames[$];
    int unsigned   mismatches = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   send_idle_pct = 35;
    int unsigned   recv_idle_pct = 55;
    int unsigned   hold_off = 0;
    int unsigned   zero_burst = 0;

    function automatic logic [15:0] odd_word(input logic [2:0] hdr, input logic [11:0] data);
        logic [15:0] w;
        w = {1'b0, hdr, data};
        if (^w == 1'b0)
            w[15] = 1'b1;
        return w;
    endfunction

    function automatic logic [11:0] scale_position(input logic signed [23:0] pos);
        longint num;
        longint den;
        longint quo;
        den = longint'(push_lim) - longint'(pull_lim);
        if (den == 0)
            return '0;
        num = (longint'(pos) - longint'(pull_lim)) * 1000;
        quo = num / den;
        return quo[11:0];
    endfunction

    function automatic frame_result_t predict_frame(input exchange_t x);
        frame_result_t r;
        logic [2:0]    hdr;
        logic [11:0]   data;
        r = '0;
        case (tx_slot)
            FRM_POSITION: begin
                hdr = TXH_POSITION;
                data = scale_position(x.position);
            end
            FRM_TEMPERATURE: begin
                hdr = TXH_TEMPERATURE;
                data = x.temperature;
            end
            FRM_RPM: begin
                hdr = TXH_RPM;
                data = x.rpm;
            end
            FRM_STATUS: begin
                hdr = TXH_STATUS;
                data = x.status;
            end
            FRM_ERROR: begin
                hdr = TXH_ERROR;
                data = x.error_flags;
            end
            default: begin
                hdr = TXH_NONE;
                data = '0;
            end
        endcase
        r.tx_word = {1'b0, hdr, data};
        if (^r.tx_word == 1'b0)
            r.tx_word[15] = 1'b1;
        tx_slot = (tx_slot >= FRM_ERROR) ? FRM_POSITION : tx_slot + 3'd1;

        if (x.rx_word == '0) begin
            if (zero_run != 8'hFF)
                zero_run = zero_run + 8'd1;
        end else begin
            zero_run = '0;
        end
        if (zero_run > tmo_lim) begin
            speed_q = hold_spd;
            mode_q = hold_md;
            command_q = hold_cmd;
            r.timed_out = 1'b1;
        end

        if (^x.rx_word) begin
            case (x.rx_word[14:12])
                RXH_SPEED:   speed_q = x.rx_word[11:0];
                RXH_MODE:    mode_q = x.rx_word[11:0];
                RXH_COMMAND: command_q = x.rx_word[11:0];
                default: ;
            endcase
        end
        r.speed = speed_q;
        r.mode = mode_q;
        r.command = command_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // output monitor
    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected transfer", got, 0);
            end else begin
                want = expected_frames.pop_front();
                if (got.tx_word !== want.tx_word)
                    report_mismatch("tx_word", got.tx_word, want.tx_word);
                if (got.speed !== want.speed)
                    report_mismatch("speed_setting", got.speed, want.speed);
                if (got.mode !== want.mode)
                    report_mismatch("mode_setting", got.mode, want.mode);
                if (got.command !== want.command)
                    report_mismatch("command_setting", got.command, want.command);
                if (got.timed_out !== want.timed_out)
                    report_mismatch("timed_out", got.timed_out, want.timed_out);
                if (got.pad !== want.pad)
                    report_mismatch("tdata padding", got.pad, want.pad);
            end
        end
    end

    // output ready: random idling, or a long hold-off when requested
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off != 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_exchange(input exchange_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= x;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_frames.push_back(predict_frame(x));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_PULL_LIMIT:    pull_lim = value;
            CFG_PUSH_LIMIT:    push_lim = value;
            CFG_TIMEOUT_LIMIT: tmo_lim = value[7:0];
            CFG_HOLD_SPEED:    hold_spd = value[11:0];
            CFG_HOLD_MODE:     hold_md = value[11:0];
            CFG_HOLD_COMMAND:  hold_cmd = value[11:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic configure(input logic signed [23:0] pull, input logic signed [23:0] push,
                             input logic [7:0] tmo, input logic [11:0] hs,
                             input logic [11:0] hm, input logic [11:0] hc);
        drain();
        write_reg(CFG_PULL_LIMIT, pull);
        write_reg(CFG_PUSH_LIMIT, push);
        write_reg(CFG_TIMEOUT_LIMIT, {16'd0, tmo});
        write_reg(CFG_HOLD_SPEED, {12'd0, hs});
        write_reg(CFG_HOLD_MODE, {12'd0, hm});
        write_reg(CFG_HOLD_COMMAND, {12'd0, hc});
        cfg_valid <= 1'b0;
    endtask

    task automatic randomize_settings();
        logic signed [23:0] pull;
        logic signed [23:0] push;
        logic [7:0]         tmo;
        int                 sel;
        pull = 24'($urandom);
        sel = $urandom_range(99);
        if (sel < 10)
            push = pull;
        else if (sel < 50)
            push = pull + 24'(int'($urandom_range(4000)) - 2000);
        else
            push = 24'($urandom);
        tmo = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        configure(pull, push, tmo, 12'($urandom), 12'($urandom), 12'($urandom));
    endtask

    function automatic logic [15:0] rand_rx_word();
        int sel;
        int cap;
        if (zero_burst != 0) begin
            zero_burst--;
            return '0;
        end
        sel = $urandom_range(99);
        if (sel < 8) begin
            cap = int'(tmo_lim) + 2;
            zero_burst = $urandom_range((cap > 30) ? 30 : cap);
            return '0;
        end
        if (sel < 65)
            return odd_word(3'($urandom_range(RXH_COMMAND, RXH_SPEED)), 12'($urandom));
        if (sel < 75)
            return odd_word(3'($urandom), 12'($urandom));
        return 16'($urandom);
    endfunction

    function automatic logic signed [23:0] rand_position();
        longint lo;
        longint hi;
        int     sel;
        lo = (pull_lim < push_lim) ? pull_lim : push_lim;
        hi = (pull_lim < push_lim) ? push_lim : pull_lim;
        sel = $urandom_range(99);
        if (sel < 70)
            return 24'(lo + longint'($urandom_range(32'(hi - lo))));
        if (sel < 80)
            return $urandom_range(1) ? pull_lim : push_lim;
        return 24'($urandom);
    endfunction

    function automatic exchange_t rand_exchange();
        exchange_t x;
        x.rx_word = rand_rx_word();
        x.position = rand_position();
        x.temperature = 12'($urandom);
        x.rpm = 12'($urandom);
        x.status = 12'($urandom);
        x.error_flags = 12'($urandom);
        return x;
    endfunction

    // default settings: every frame kind, header decode, field extremes
    task automatic test_default_frames();
        logic [15:0]        rx_list[5];
        logic signed [23:0] pos_list[5];
        exchange_t          x;
        rx_list = '{odd_word(RXH_SPEED, 12'hFFF), odd_word(RXH_MODE, 12'h000),
                    odd_word(RXH_COMMAND, 12'hABC), odd_word(3'd7, 12'hFFF),
                    {1'b0, RXH_SPEED, 12'h003}};
        pos_list = '{24'sd500, 24'sd1000, 24'sd0, -24'sd1, 24'sh7FFFFF};
        for (int i = 0; i < 5; i++) begin
            x.rx_word = rx_list[i];
            x.position = pos_list[i];
            x.temperature = i[0] ? 12'hFFF : 12'h000;
            x.rpm = i[0] ? 12'h000 : 12'hFFF;
            x.status = i[1] ? 12'hFFF : 12'h000;
            x.error_flags = i[1] ? 12'h000 : 12'hFFF;
            send_exchange(x);
        end
    endtask

    // widest, reversed and equal travel limits
    task automatic test_limit_extremes();
        exchange_t x;
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: configure(24'sh800000, 24'sh7FFFFF, 8'd10, '0, '0, '0);
                1: configure(24'sh7FFFFF, 24'sh800000, 8'd10, '0, '0, '0);
                default: configure(24'sd1234, 24'sd1234, 8'd10, '0, '0, '0);
            endcase
            for (int j = 0; j < 5; j++) begin
                x = rand_exchange();
                x.rx_word = (j == 0) ? 16'hFFFF : (j == 1) ? 16'h8000 : x.rx_word;
                if (j == 0)
                    x.position = (k == 1) ? 24'sh800000 : 24'sh7FFFFF;
                send_exchange(x);
            end
        end
    endtask

    // hold values forced after zero words, cleared by any nonzero word
    task automatic test_link_timeout();
        exchange_t x;
        logic [15:0] rx_list[8];
        configure(24'sd0, 24'sd1000, 8'd0, 12'hFFF, 12'h000, 12'hAAA);
        rx_list = '{16'h0000, odd_word(RXH_SPEED, 12'h055), 16'h0000,
                    16'h0000, 16'h0003, 16'h0000, odd_word(RXH_COMMAND, 12'h5A5), 16'h0000};
        for (int i = 0; i < 8; i++) begin
            if (i == 3)
                configure(24'sd0, 24'sd1000, 8'd2, 12'h123, 12'hFFF, 12'h000);
            x = rand_exchange();
            x.rx_word = rx_list[i];
            send_exchange(x);
        end
    endtask

    // zero counter saturates at its top value and never wraps
    task automatic test_zero_run_saturation();
        exchange_t x;
        configure(24'sd0, 24'sd1000, 8'd255, 12'h111, 12'h222, 12'h333);
        for (int i = 0; i < 258; i++) begin
            x = rand_exchange();
            x.rx_word = '0;
            send_exchange(x);
        end
        configure(24'sd0, 24'sd1000, 8'd254, 12'h444, 12'h555, 12'h666);
        for (int i = 0; i < 3; i++) begin
            x = rand_exchange();
            x.rx_word = (i == 2) ? odd_word(RXH_MODE, 12'h777) : 16'h0000;
            send_exchange(x);
        end
    endtask

    // long output hold-off while input keeps offering transfers
    task automatic test_backpressure();
        randomize_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        hold_off = STALL_CYCLES;
        @(negedge aclk);
        for (int i = 0; i < 40; i++)
            send_exchange(rand_exchange());
    endtask

    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
        for (int c = 0; c < 3; c++) begin
            randomize_settings();
            send_idle_pct = snd_pct;
            recv_idle_pct = rcv_pct;
            zero_burst = 0;
            for (int i = 0; i < 75; i++)
                send_exchange(rand_exchange());
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_default_frames();
        test_limit_extremes();
        test_link_timeout();
        test_zero_run_saturation();
        test_random_traffic(35, 55);
        test_random_traffic(55, 35);
        test_random_traffic(0, 0);
        test_backpressure();
        drain();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
